// File: rtl/core/tgp_pkg.sv
// Shared types and codes for the turtle grid plotter.
// Used by the front decoder, the command queue and the back engine.
package tgp_pkg;

    // Field widths of the command and result words
    localparam int unsigned OP_W       = 3;
    localparam int unsigned DIST_W     = 5;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned HEAD_W     = 2;
    localparam int unsigned ROW_BITS_W = 32;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Opcodes on the op port
    localparam logic [OP_W-1:0] OP_PEN_UP   = 3'd0;
    localparam logic [OP_W-1:0] OP_PEN_DOWN = 3'd1;
    localparam logic [OP_W-1:0] OP_TURN_R   = 3'd2;
    localparam logic [OP_W-1:0] OP_TURN_L   = 3'd3;
    localparam logic [OP_W-1:0] OP_FORWARD  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_ROW = 3'd5;

    // Headings
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd3;

    // Command class after decode
    typedef enum logic [2:0] {
        K_PEN_UP,
        K_PEN_DOWN,
        K_TURN_R,
        K_TURN_L,
        K_FORWARD,
        K_READ_ROW,
        K_NOP
    } cmd_kind_t;

    // One queued command word
    typedef struct packed {
        cmd_kind_t          kind;
        logic [DIST_W-1:0]  distance;
        logic [POS_W-1:0]   row_index;
    } queue_word_t;

endpackage

// File: rtl/core/turtle_grid_plotter.sv
// Turtle plotter on a square bitmap. Pen, turn, no-op, unmarked moves and out-of-range reads
// finish from the idle state; a row read passes through the run and drain states; a move
// with the pen down reads and rewrites each of its N rows in the run state and then drains
// (1 row horizontally, up to EDGE rows vertically). The back engine takes a new command only
// in the idle state; a 2-word queue accepts commands meanwhile. Results cannot be stalled.
// Reset clears the bitmap at once through per-row valid bits; the pen is up, heading right.
module turtle_grid_plotter
    import tgp_pkg::*;
#(
    parameter int unsigned GRID_SIZE = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        op,
    input  logic [DIST_W-1:0]      distance,
    input  logic [POS_W-1:0]       row_index,
    output logic                   done,
    output logic [ROW_BITS_W-1:0]  row_bits,
    output logic [POS_W-1:0]       cur_row,
    output logic [POS_W-1:0]       cur_col,
    output logic [HEAD_W-1:0]      heading,
    output logic                   pen_down,
    output logic                   clipped
);

    localparam int unsigned EDGE  = (GRID_SIZE > ROW_BITS_W) ? ROW_BITS_W : GRID_SIZE;
    localparam int unsigned ROW_W = $clog2(EDGE);

    logic        queue_full;
    logic        queue_not_empty;
    logic        push;
    logic        pop;
    queue_word_t push_word;
    queue_word_t head_word;

    tgp_front u_front (
        .start      (start),
        .queue_full (queue_full),
        .op         (op),
        .distance   (distance),
        .row_index  (row_index),
        .busy       (busy),
        .push       (push),
        .push_word  (push_word)
    );

    tgp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_word (head_word)
    );

    tgp_back #(
        .EDGE  (EDGE),
        .ROW_W (ROW_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (head_word),
        .cmd_pop   (pop),
        .done      (done),
        .row_bits  (row_bits),
        .cur_row   (cur_row),
        .cur_col   (cur_col),
        .heading   (heading),
        .pen_down  (pen_down),
        .clipped   (clipped)
    );

endmodule

// File: rtl/core/tgp_front.sv
// Front end: accepts command words and classifies the opcode.
// Depends on tgp_pkg; feeds tgp_queue.
module tgp_front
    import tgp_pkg::*;
(
    input  logic                start,
    input  logic                queue_full,
    input  logic [OP_W-1:0]     op,
    input  logic [DIST_W-1:0]   distance,
    input  logic [POS_W-1:0]    row_index,
    output logic                busy,
    output logic                push,
    output queue_word_t         push_word
);

    cmd_kind_t kind;

    // Classify the opcode; unused codes become no-ops
    always_comb
    begin
        unique case (op)
            OP_PEN_UP:   kind = K_PEN_UP;
            OP_PEN_DOWN: kind = K_PEN_DOWN;
            OP_TURN_R:   kind = K_TURN_R;
            OP_TURN_L:   kind = K_TURN_L;
            OP_FORWARD:  kind = K_FORWARD;
            OP_READ_ROW: kind = K_READ_ROW;
            default:     kind = K_NOP;
        endcase
    end

    // Hold off the sender while the queue is full
    assign busy = queue_full;
    assign push = start && !queue_full;

    assign push_word.kind      = kind;
    assign push_word.distance  = distance;
    assign push_word.row_index = row_index;

endmodule

// File: rtl/core/tgp_queue.sv
// Short command queue between the front decoder and the back engine.
// Depends on tgp_pkg for the queued word type and depth.
module tgp_queue
    import tgp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_word_t  push_word,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output queue_word_t  head_word
);

    queue_word_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: rtl/core/tgp_back.sv
// Back engine: turtle state, bitmap memory and the row sweep for moves and reads.
// Depends on tgp_pkg; takes words from tgp_queue and drives the result ports.
module tgp_back
    import tgp_pkg::*;
#(
    parameter int unsigned EDGE  = 32,
    parameter int unsigned ROW_W = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  queue_word_t            cmd,
    output logic                   cmd_pop,
    output logic                   done,
    output logic [ROW_BITS_W-1:0]  row_bits,
    output logic [POS_W-1:0]       cur_row,
    output logic [POS_W-1:0]       cur_col,
    output logic [HEAD_W-1:0]      heading,
    output logic                   pen_down,
    output logic                   clipped
);

    localparam logic [POS_W-1:0] EDGE_MAX = POS_W'(EDGE - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    // Turtle state
    logic [POS_W-1:0]  pos_row_reg, pos_row_next;
    logic [POS_W-1:0]  pos_col_reg, pos_col_next;
    logic [HEAD_W-1:0] dir_reg, dir_next;
    logic              pen_reg, pen_next;

    // Sweep control
    logic [ROW_W-1:0]  addr_reg, addr_next;
    logic [ROW_W-1:0]  last_reg, last_next;
    logic [EDGE-1:0]   mask_reg, mask_next;
    logic              is_read_reg, is_read_next;
    logic              clip_reg, clip_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [ROW_W-1:0]  rd_addr_reg;

    // Bitmap storage
    logic [EDGE-1:0]   mem [EDGE];
    logic [EDGE-1:0]   row_valid_reg;
    logic [EDGE-1:0]   rdata_reg;
    logic              rvalid_reg;
    logic [EDGE-1:0]   eff_row;
    logic              rd_en;
    logic              wr_en;

    // Result register
    logic                  done_reg, done_next;
    logic [ROW_BITS_W-1:0] out_bits_reg, out_bits_next;
    logic [POS_W-1:0]      out_row_reg, out_row_next;
    logic [POS_W-1:0]      out_col_reg, out_col_next;
    logic [HEAD_W-1:0]     out_head_reg, out_head_next;
    logic                  out_pen_reg, out_pen_next;
    logic                  out_clip_reg, out_clip_next;

    // Move geometry
    logic              is_vert;
    logic              inc;
    logic [POS_W-1:0]  from_pos;
    logic [POS_W-1:0]  room;
    logic [POS_W-1:0]  to_pos;
    logic              adv_clip;
    logic [POS_W-1:0]  lo_pos;
    logic [POS_W-1:0]  hi_pos;
    logic [EDGE-1:0]   move_mask;
    logic [ROW_W-1:0]  row_lo;
    logic [ROW_W-1:0]  row_hi;
    logic              ridx_ok;

    logic                  emit;
    logic [ROW_BITS_W-1:0] emit_bits;
    logic                  emit_clip;

    // A row never written reads as cleared
    assign eff_row = rvalid_reg ? rdata_reg : '0;
    assign rd_en   = (state_reg == S_RUN);
    assign wr_en   = rd_pend_reg && !is_read_reg;
    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;
    assign ridx_ok = ({1'b0, cmd.row_index} < (POS_W + 1)'(EDGE));

    // Target position, clipped at the grid edge
    always_comb
    begin
        is_vert  = (dir_reg == HEAD_UP) || (dir_reg == HEAD_DOWN);
        inc      = (dir_reg == HEAD_DOWN) || (dir_reg == HEAD_RIGHT);
        from_pos = is_vert ? pos_row_reg : pos_col_reg;
        room     = EDGE_MAX - from_pos;
        adv_clip = 1'b0;
        if (inc)
        begin
            if (cmd.distance > room)
            begin
                adv_clip = 1'b1;
                to_pos   = EDGE_MAX;
            end
            else
            begin
                to_pos = from_pos + cmd.distance;
            end
        end
        else
        begin
            if (cmd.distance > from_pos)
            begin
                adv_clip = 1'b1;
                to_pos   = '0;
            end
            else
            begin
                to_pos = from_pos - cmd.distance;
            end
        end
        lo_pos = inc ? from_pos : to_pos;
        hi_pos = inc ? to_pos : from_pos;
        for (int i = 0; i < EDGE; i++)
        begin
            if (is_vert)
            begin
                move_mask[i] = (POS_W'(i) == pos_col_reg);
            end
            else
            begin
                move_mask[i] = (POS_W'(i) >= lo_pos) && (POS_W'(i) <= hi_pos);
            end
        end
        row_lo = is_vert ? lo_pos[ROW_W-1:0] : pos_row_reg[ROW_W-1:0];
        row_hi = is_vert ? hi_pos[ROW_W-1:0] : pos_row_reg[ROW_W-1:0];
    end

    // Sequence commands and the row sweep
    always_comb
    begin
        state_next    = state_reg;
        pos_row_next  = pos_row_reg;
        pos_col_next  = pos_col_reg;
        dir_next      = dir_reg;
        pen_next      = pen_reg;
        addr_next     = addr_reg;
        last_next     = last_reg;
        mask_next     = mask_reg;
        is_read_next  = is_read_reg;
        clip_next     = clip_reg;
        rd_pend_next  = 1'b0;
        emit          = 1'b0;
        emit_bits     = '0;
        emit_clip     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        K_PEN_UP:
                        begin
                            pen_next = 1'b0;
                            emit     = 1'b1;
                        end
                        K_PEN_DOWN:
                        begin
                            pen_next = 1'b1;
                            emit     = 1'b1;
                        end
                        K_TURN_R:
                        begin
                            dir_next = dir_reg + 1'b1;
                            emit     = 1'b1;
                        end
                        K_TURN_L:
                        begin
                            dir_next = dir_reg - 1'b1;
                            emit     = 1'b1;
                        end
                        K_FORWARD:
                        begin
                            if (is_vert)
                            begin
                                pos_row_next = to_pos;
                            end
                            else
                            begin
                                pos_col_next = to_pos;
                            end
                            if (pen_reg)
                            begin
                                addr_next    = row_lo;
                                last_next    = row_hi;
                                mask_next    = move_mask;
                                is_read_next = 1'b0;
                                clip_next    = adv_clip;
                                state_next   = S_RUN;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                emit_clip = adv_clip;
                            end
                        end
                        K_READ_ROW:
                        begin
                            if (ridx_ok)
                            begin
                                addr_next    = cmd.row_index[ROW_W-1:0];
                                last_next    = cmd.row_index[ROW_W-1:0];
                                is_read_next = 1'b1;
                                clip_next    = 1'b0;
                                state_next   = S_RUN;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                rd_pend_next = 1'b1;
                if (addr_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                emit       = 1'b1;
                emit_bits  = is_read_reg ? ROW_BITS_W'(eff_row) : '0;
                emit_clip  = clip_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the result word
        done_next     = emit;
        out_bits_next = out_bits_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_head_next = out_head_reg;
        out_pen_next  = out_pen_reg;
        out_clip_next = out_clip_reg;
        if (emit)
        begin
            out_bits_next = emit_bits;
            out_row_next  = pos_row_next;
            out_col_next  = pos_col_next;
            out_head_next = dir_next;
            out_pen_next  = pen_next;
            out_clip_next = emit_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_row_reg   <= '0;
            pos_col_reg   <= '0;
            dir_reg       <= HEAD_RIGHT;
            pen_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            is_read_reg   <= 1'b0;
            done_reg      <= 1'b0;
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            dir_reg     <= dir_next;
            pen_reg     <= pen_next;
            rd_pend_reg <= rd_pend_next;
            is_read_reg <= is_read_next;
            done_reg    <= done_next;
            if (wr_en)
            begin
                row_valid_reg[rd_addr_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= row_valid_reg[addr_reg];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        last_reg     <= last_next;
        mask_reg     <= mask_next;
        clip_reg     <= clip_next;
        rd_addr_reg  <= addr_reg;
        out_bits_reg <= out_bits_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_head_reg <= out_head_next;
        out_pen_reg  <= out_pen_next;
        out_clip_reg <= out_clip_next;
    end

    // Bitmap: one registered read and one merged write per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[rd_addr_reg] <= eff_row | mask_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign done     = done_reg;
    assign row_bits = out_bits_reg;
    assign cur_row  = out_row_reg;
    assign cur_col  = out_col_reg;
    assign heading  = out_head_reg;
    assign pen_down = out_pen_reg;
    assign clipped  = out_clip_reg;

endmodule
